@@ hdl/podo_pkg.sv @@
// Shared widths, codes, command and status types for the planar odometry accumulator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package podo_pkg;

    // Field widths.
    localparam int CW         = 24;               // coordinate and depth width, Q16.8
    localparam int DW         = 48;               // distance width, Q40.8
    localparam int TICK_W     = 16;               // idle tick counter and stale limit
    localparam int CMD_W      = 2;
    localparam int UNIT_SEL_W = 3;

    // Unit factors are unsigned Q.24 values.
    localparam int UNIT_FRAC  = 24;
    localparam int UNIT_W     = 26;
    localparam int HI_W       = DW - UNIT_FRAC;

    // Square root: radicand dx^2+dy^2 needs 2*CW+1 bits, padded to an even count.
    localparam int SQ_W       = 2 * CW;
    localparam int ROOT_W     = CW + 1;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 1;
    localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

    // Shared multiplier operand widths.
    localparam int MUL_A_W0   = (CW > HI_W) ? CW : HI_W;
    localparam int MUL_A_W    = (MUL_A_W0 > UNIT_FRAC) ? MUL_A_W0 : UNIT_FRAC;
    localparam int MUL_B_W    = (CW > UNIT_W) ? CW : UNIT_W;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = (CW > TICK_W) ? CW : TICK_W;

    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_SEL    = 2'd2;

    localparam logic [CW-1:0]     DEPTH_THR_RESET   = {1'b0, {(CW-1){1'b1}}};
    localparam logic [TICK_W-1:0] STALE_TICKS_RESET = 16'd10;

    // Input item kinds.
    localparam logic [CMD_W-1:0] CMD_POS   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEPTH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // Output unit codes.
    localparam logic [UNIT_SEL_W-1:0] UNIT_METRES = 3'd0;
    localparam logic [UNIT_SEL_W-1:0] UNIT_FEET   = 3'd1;
    localparam logic [UNIT_SEL_W-1:0] UNIT_YARDS  = 3'd2;
    localparam logic [UNIT_SEL_W-1:0] UNIT_KM     = 3'd3;
    localparam logic [UNIT_SEL_W-1:0] UNIT_MILES  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;     // capture the accepted input item
        logic commit;      // apply the item to position, depth and tick state
        logic diff;        // form the absolute coordinate differences
        logic sq_x;        // multiply dx by dx
        logic sq_y;        // multiply dy by dy
        logic root_start;  // sum the squares and start the square root
        logic acc;         // add the step to the accumulators
        logic sc_hi;       // multiply the upper part of the total by the unit factor
        logic sc_lo;       // multiply the lower part of the total by the unit factor
        logic sc_sum;      // combine the partial products with saturation
        logic out_load;    // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_pending; // position item with a previous position on record
        logic root_done;    // square root finished this cycle
    } t_sts;

    // Unit factor in Q.24; unknown codes fall back to metres.
    function automatic logic [UNIT_W-1:0] unit_factor(input logic [UNIT_SEL_W-1:0] sel);
        logic [UNIT_W-1:0] f;
        unique case (sel)
            UNIT_FEET:  f = UNIT_W'(32'd55043361);
            UNIT_YARDS: f = UNIT_W'(32'd18347731);
            UNIT_KM:    f = UNIT_W'(32'd16777);
            UNIT_MILES: f = UNIT_W'(32'd10425);
            default:    f = UNIT_W'(32'd16777216);
        endcase
        return f;
    endfunction

endpackage

@@ hdl/podo_isqrt.sv @@
// Bit-serial floor square root, two radicand bits per cycle, restoring form.
// Uses widths from podo_pkg.
`timescale 1ns / 1ps

module podo_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [podo_pkg::RAD_W-1:0]  i_radicand,
    output logic                        o_done,
    output logic [podo_pkg::ROOT_W-1:0] o_root
);

    logic                            r_busy;
    logic                            r_done;
    logic [podo_pkg::ROOT_CNT_W-1:0] r_cnt;
    logic [podo_pkg::RAD_W-1:0]      r_rad;
    logic [podo_pkg::REM_W-1:0]      r_rem;
    logic [podo_pkg::ROOT_W-1:0]     r_root;

    logic [1:0]                      w_pair;
    logic [podo_pkg::REM_W+1:0]      w_shift;
    logic [podo_pkg::REM_W+1:0]      w_trial;
    logic [podo_pkg::REM_W+1:0]      w_diff;
    logic                            w_ge;

    // One iteration: bring down two bits and try to subtract 4*root+1.
    always_comb begin
        w_pair  = r_rad[podo_pkg::RAD_W-1 -: 2];
        w_shift = {r_rem, w_pair};
        w_trial = {1'b0, r_root, 2'b01};
        w_ge    = (w_shift >= w_trial);
        w_diff  = w_shift - w_trial;
    end

    // Iteration registers; the counter runs one step per root bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= podo_pkg::ROOT_CNT_W'(podo_pkg::ROOT_W);
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[podo_pkg::RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[podo_pkg::REM_W-1:0] : w_shift[podo_pkg::REM_W-1:0];
            r_root <= {r_root[podo_pkg::ROOT_W-2:0], w_ge};
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == podo_pkg::ROOT_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ hdl/podo_dpath.sv @@
// Datapath: configuration registers, odometry state, shared multiplier, square root,
// saturating accumulators, unit scaling and result register. Uses podo_pkg and podo_isqrt.
`timescale 1ns / 1ps

module podo_dpath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [podo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [podo_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [podo_pkg::CMD_W-1:0]      i_in_cmd,
    input  logic [podo_pkg::CW-1:0]         i_in_pos_x,
    input  logic [podo_pkg::CW-1:0]         i_in_pos_y,
    input  logic [podo_pkg::CW-1:0]         i_in_depth,
    input  podo_pkg::t_cmd                  i_cmd,
    output podo_pkg::t_sts                  o_sts,
    output logic [podo_pkg::DW-1:0]         o_total_distance,
    output logic [podo_pkg::DW-1:0]         o_depth_distance,
    output logic [podo_pkg::DW-1:0]         o_scaled_distance,
    output logic                            o_stale
);

    // Configuration registers.
    logic [podo_pkg::CW-1:0]         r_depth_thr;
    logic [podo_pkg::TICK_W-1:0]     r_stale_ticks;
    logic [podo_pkg::UNIT_SEL_W-1:0] r_unit_sel;

    // Odometry state.
    logic                            r_have_pos;
    logic [podo_pkg::CW-1:0]         r_last_x;
    logic [podo_pkg::CW-1:0]         r_last_y;
    logic [podo_pkg::CW-1:0]         r_cur_depth;
    logic [podo_pkg::DW-1:0]         r_total;
    logic [podo_pkg::DW-1:0]         r_at_depth;
    logic [podo_pkg::TICK_W-1:0]     r_idle;

    // Captured item and working registers.
    logic [podo_pkg::CMD_W-1:0]      r_in_cmd;
    logic [podo_pkg::CW-1:0]         r_in_x;
    logic [podo_pkg::CW-1:0]         r_in_y;
    logic [podo_pkg::CW-1:0]         r_in_depth;
    logic [podo_pkg::CW-1:0]         r_dx;
    logic [podo_pkg::CW-1:0]         r_dy;
    logic [podo_pkg::SQ_W-1:0]       r_sqx;
    logic [podo_pkg::PROD_W-1:0]     r_prod;
    logic [podo_pkg::PROD_W-1:0]     r_phi;
    logic [podo_pkg::DW-1:0]         r_scaled;

    // Result register.
    logic [podo_pkg::DW-1:0]         r_out_total;
    logic [podo_pkg::DW-1:0]         r_out_depth;
    logic [podo_pkg::DW-1:0]         r_out_scaled;
    logic                            r_out_stale;

    logic [podo_pkg::CW:0]           w_ddx;
    logic [podo_pkg::CW:0]           w_ddy;
    logic [podo_pkg::CW:0]           w_adx;
    logic [podo_pkg::CW:0]           w_ady;
    logic [podo_pkg::MUL_A_W-1:0]    w_mul_a;
    logic [podo_pkg::MUL_B_W-1:0]    w_mul_b;
    logic [podo_pkg::PROD_W-1:0]     w_prod;
    logic [podo_pkg::UNIT_W-1:0]     w_factor;
    logic [podo_pkg::RAD_W-1:0]      w_rad;
    logic                            w_root_done;
    logic [podo_pkg::ROOT_W-1:0]     w_root;
    logic [podo_pkg::DW:0]           w_tot_sum;
    logic [podo_pkg::DW:0]           w_dep_sum;
    logic                            w_deep;
    logic [podo_pkg::UNIT_W-1:0]     w_frac;
    logic [podo_pkg::DW:0]           w_sc_sum;
    logic                            w_sc_over;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_thr   <= podo_pkg::DEPTH_THR_RESET;
            r_stale_ticks <= podo_pkg::STALE_TICKS_RESET;
            r_unit_sel    <= podo_pkg::UNIT_METRES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                podo_pkg::REG_DEPTH_THR:   r_depth_thr   <= i_cfg_wdata[podo_pkg::CW-1:0];
                podo_pkg::REG_STALE_TICKS: r_stale_ticks <= i_cfg_wdata[podo_pkg::TICK_W-1:0];
                podo_pkg::REG_UNIT_SEL:    r_unit_sel    <= i_cfg_wdata[podo_pkg::UNIT_SEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Absolute coordinate differences; the signed difference needs one extra bit.
    always_comb begin
        w_ddx = {r_in_x[podo_pkg::CW-1], r_in_x} - {r_last_x[podo_pkg::CW-1], r_last_x};
        w_ddy = {r_in_y[podo_pkg::CW-1], r_in_y} - {r_last_y[podo_pkg::CW-1], r_last_y};
        w_adx = w_ddx[podo_pkg::CW] ? (~w_ddx + 1'b1) : w_ddx;
        w_ady = w_ddy[podo_pkg::CW] ? (~w_ddy + 1'b1) : w_ddy;
    end

    // Shared multiplier operand selection.
    always_comb begin
        w_factor = podo_pkg::unit_factor(r_unit_sel);
        w_mul_a  = podo_pkg::MUL_A_W'(r_dx);
        w_mul_b  = podo_pkg::MUL_B_W'(r_dx);
        if (i_cmd.sq_y) begin
            w_mul_a = podo_pkg::MUL_A_W'(r_dy);
            w_mul_b = podo_pkg::MUL_B_W'(r_dy);
        end else if (i_cmd.sc_hi) begin
            w_mul_a = podo_pkg::MUL_A_W'(r_total[podo_pkg::DW-1:podo_pkg::UNIT_FRAC]);
            w_mul_b = podo_pkg::MUL_B_W'(w_factor);
        end else if (i_cmd.sc_lo) begin
            w_mul_a = podo_pkg::MUL_A_W'(r_total[podo_pkg::UNIT_FRAC-1:0]);
            w_mul_b = podo_pkg::MUL_B_W'(w_factor);
        end
        w_prod = w_mul_a * w_mul_b;
    end

    // Sum of squares feeds the square root unit.
    assign w_rad = {2'b00, r_sqx} + {2'b00, r_prod[podo_pkg::SQ_W-1:0]};

    podo_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.root_start),
        .i_radicand (w_rad),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    // Saturating accumulator sums and the depth test.
    always_comb begin
        w_tot_sum = {1'b0, r_total} + (podo_pkg::DW+1)'(w_root);
        w_dep_sum = {1'b0, r_at_depth} + (podo_pkg::DW+1)'(w_root);
        w_deep    = ($signed(r_cur_depth) > $signed(r_depth_thr));
    end

    // Scaled total: upper partial product plus the integer part of the lower one.
    always_comb begin
        w_frac    = r_prod[podo_pkg::UNIT_FRAC+podo_pkg::UNIT_W-1:podo_pkg::UNIT_FRAC];
        w_sc_sum  = {1'b0, r_phi[podo_pkg::DW-1:0]} + (podo_pkg::DW+1)'(w_frac);
        w_sc_over = (|r_phi[podo_pkg::PROD_W-1:podo_pkg::DW]) || w_sc_sum[podo_pkg::DW];
    end

    // Working registers, which carry payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_cmd   <= i_in_cmd;
            r_in_x     <= i_in_pos_x;
            r_in_y     <= i_in_pos_y;
            r_in_depth <= i_in_depth;
        end
        if (i_cmd.diff) begin
            r_dx <= w_adx[podo_pkg::CW-1:0];
            r_dy <= w_ady[podo_pkg::CW-1:0];
        end
        if (i_cmd.sq_x || i_cmd.sq_y || i_cmd.sc_hi || i_cmd.sc_lo) begin
            r_prod <= w_prod;
        end
        if (i_cmd.sq_y) begin
            r_sqx <= r_prod[podo_pkg::SQ_W-1:0];
        end
        if (i_cmd.sc_lo) begin
            r_phi <= r_prod;
        end
        if (i_cmd.sc_sum) begin
            r_scaled <= w_sc_over ? '1 : w_sc_sum[podo_pkg::DW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_total  <= r_total;
            r_out_depth  <= r_at_depth;
            r_out_scaled <= r_scaled;
            r_out_stale  <= (r_idle > r_stale_ticks);
        end
    end

    // Odometry state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_pos  <= 1'b0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_cur_depth <= '0;
            r_total     <= '0;
            r_at_depth  <= '0;
            r_idle      <= '0;
        end else begin
            if (i_cmd.acc) begin
                r_total <= w_tot_sum[podo_pkg::DW] ? '1 : w_tot_sum[podo_pkg::DW-1:0];
                if (w_deep) begin
                    r_at_depth <= w_dep_sum[podo_pkg::DW] ? '1 : w_dep_sum[podo_pkg::DW-1:0];
                end
            end
            if (i_cmd.commit) begin
                unique case (r_in_cmd)
                    podo_pkg::CMD_POS: begin
                        r_have_pos <= 1'b1;
                        r_last_x   <= r_in_x;
                        r_last_y   <= r_in_y;
                        r_idle     <= '0;
                    end
                    podo_pkg::CMD_DEPTH: begin
                        r_cur_depth <= r_in_depth;
                        r_idle      <= '0;
                    end
                    podo_pkg::CMD_TICK: begin
                        if (r_idle != '1) begin
                            r_idle <= r_idle + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_sts.step_pending = (r_in_cmd == podo_pkg::CMD_POS) && r_have_pos;
    assign o_sts.root_done    = w_root_done;

    assign o_total_distance  = r_out_total;
    assign o_depth_distance  = r_out_depth;
    assign o_scaled_distance = r_out_scaled;
    assign o_stale           = r_out_stale;

endmodule

@@ hdl/podo_ctrl.sv @@
// Controller: sequences one item through the datapath and runs both stream handshakes.
// Uses the command and status types of podo_pkg.
`timescale 1ns / 1ps

module podo_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  podo_pkg::t_sts i_sts,
    output podo_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_SUM,
        S_ROOT,
        S_ACC,
        S_SC_HI,
        S_SC_LO,
        S_SC_SUM,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_s_ready;
    logic   r_m_valid;
    logic   w_accept;
    logic   w_out_load;

    assign w_accept   = (r_state == S_IDLE) && i_s_tvalid && r_s_ready;
    assign w_out_load = (r_state == S_OUT) && (!r_m_valid || i_m_tready);

    // Datapath commands decoded from the state.
    always_comb begin
        o_cmd            = '0;
        o_cmd.load_in    = w_accept;
        o_cmd.out_load   = w_out_load;
        unique case (r_state)
            S_APPLY:  o_cmd.commit     = !i_sts.step_pending;
            S_DIFF:   o_cmd.diff       = 1'b1;
            S_SQX:    o_cmd.sq_x       = 1'b1;
            S_SQY:    o_cmd.sq_y       = 1'b1;
            S_SUM:    o_cmd.root_start = 1'b1;
            S_ACC: begin
                o_cmd.acc    = 1'b1;
                o_cmd.commit = 1'b1;
            end
            S_SC_HI:  o_cmd.sc_hi      = 1'b1;
            S_SC_LO:  o_cmd.sc_lo      = 1'b1;
            S_SC_SUM: o_cmd.sc_sum     = 1'b1;
            default: ;
        endcase
    end

    // State, input ready and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_s_ready <= 1'b1;
            r_m_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state   <= S_APPLY;
                        r_s_ready <= 1'b0;
                    end
                end
                S_APPLY:  r_state <= i_sts.step_pending ? S_DIFF : S_SC_HI;
                S_DIFF:   r_state <= S_SQX;
                S_SQX:    r_state <= S_SQY;
                S_SQY:    r_state <= S_SUM;
                S_SUM:    r_state <= S_ROOT;
                S_ROOT: begin
                    if (i_sts.root_done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC:    r_state <= S_SC_HI;
                S_SC_HI:  r_state <= S_SC_LO;
                S_SC_LO:  r_state <= S_SC_SUM;
                S_SC_SUM: r_state <= S_OUT;
                S_OUT: begin
                    if (w_out_load) begin
                        r_state   <= S_IDLE;
                        r_s_ready <= 1'b1;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = r_s_ready;
    assign o_m_tvalid = r_m_valid;

endmodule

@@ hdl/planar_odometry_accumulator.sv @@
// Top level of the planar odometry accumulator: stream ports and configuration port.
// Instantiates podo_ctrl and podo_dpath; uses podo_pkg.
`timescale 1ns / 1ps

// Usage:
// Items arrive on the slave stream. tuser carries the kind: position sample,
// depth update or time tick; tdata carries pos_x, pos_y and depth. Every item
// gives one result on the master stream with the total path length, the path
// length below the depth threshold, the total in the selected unit and, in
// tuser, the stale flag.
// A position item after the first passes the coordinate differences, the
// squares, the bit-serial square root (one root bit at a time, then a done
// report) and the accumulation; the shared multiplier forms dx^2, dy^2 and
// two partial products of the unit scaling in separate states. Depth, tick
// and first position items go straight to the scaling. One item is worked
// on at a time; tready rises again once the result is in the output
// register, so a new item is taken while the receiver has not yet taken that
// result. If the receiver stalls, the result stays in the output register
// and the next item is held in its last step until the register is free.
// Reset clears the totals, the stored position, depth and tick count, and
// loads the register defaults. Configuration writes take effect at once; the
// user must make them while the block is idle; the block does not enforce it.
module planar_odometry_accumulator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Slave stream. tdata: pos_x [23:0], pos_y [47:24], depth [71:48].
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [3*podo_pkg::CW-1:0]       i_s_tdata,
    // tuser: cmd [1:0].
    input  logic [podo_pkg::CMD_W-1:0]      i_s_tuser,
    // Master stream. tdata: total_distance [47:0], depth_distance [95:48],
    // scaled_distance [143:96].
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [3*podo_pkg::DW-1:0]       o_m_tdata,
    // tuser: stale [0].
    output logic [0:0]                      o_m_tuser,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [podo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [podo_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    podo_pkg::t_cmd              w_cmd;
    podo_pkg::t_sts              w_sts;
    logic [podo_pkg::DW-1:0]     w_total;
    logic [podo_pkg::DW-1:0]     w_depth_dist;
    logic [podo_pkg::DW-1:0]     w_scaled;
    logic                        w_stale;

    // Sequencer for one item at a time.
    podo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Arithmetic, state and result register.
    podo_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_cmd          (i_s_tuser),
        .i_in_pos_x        (i_s_tdata[podo_pkg::CW-1:0]),
        .i_in_pos_y        (i_s_tdata[2*podo_pkg::CW-1:podo_pkg::CW]),
        .i_in_depth        (i_s_tdata[3*podo_pkg::CW-1:2*podo_pkg::CW]),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_total_distance  (w_total),
        .o_depth_distance  (w_depth_dist),
        .o_scaled_distance (w_scaled),
        .o_stale           (w_stale)
    );

    // Pack the result fields, first field in the lowest bits.
    assign o_m_tdata = {w_scaled, w_depth_dist, w_total};
    assign o_m_tuser = w_stale;

endmodule

@@ hdl/podo_checker.sv @@
// Port-level checker for the planar odometry accumulator, bound to the top level.
// Uses podo_pkg widths; sees the top-level ports only.
`timescale 1ns / 1ps

module podo_port_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [3*podo_pkg::CW-1:0]       i_s_tdata,
    input logic [podo_pkg::CMD_W-1:0]      i_s_tuser,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [3*podo_pkg::DW-1:0]       o_m_tdata,
    input logic [0:0]                      o_m_tuser,
    input logic                            i_cfg_we,
    input logic [podo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [podo_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser)))
        else $error("stalled result changed or dropped");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second item taken while one is in work");

    // Distance at depth is a part of the total path length.
    a_depth_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2*podo_pkg::DW-1:podo_pkg::DW]
            <= o_m_tdata[podo_pkg::DW-1:0]))
        else $error("depth distance exceeds total distance");

endmodule

bind planar_odometry_accumulator podo_port_checker u_podo_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tdata   (i_s_tdata),
    .i_s_tuser   (i_s_tuser),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .i_cfg_wdata (i_cfg_wdata)
);

@@ verif/podo_checker.sv @@
// Result checker for the planar odometry accumulator: watches both streams and the
// configuration port, predicts every result and compares it field by field.
// Depends on podo_pkg for widths, command codes and register indexes.
`timescale 1ns / 1ps

module podo_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream. tdata: pos_x [23:0], pos_y [47:24], depth [71:48].
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [3*podo_pkg::CW-1:0]       i_s_tdata,
    // tuser: cmd [1:0].
    input  logic [podo_pkg::CMD_W-1:0]      i_s_tuser,
    // Result stream. tdata: total_distance [47:0], depth_distance [95:48],
    // scaled_distance [143:96].
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [3*podo_pkg::DW-1:0]       i_m_tdata,
    // tuser: stale [0].
    input  logic [0:0]                      i_m_tuser,
    // Configuration writes.
    input  logic                            i_cfg_we,
    input  logic [podo_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [podo_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                              o_errors,
    output int                              o_pending
);

    localparam logic [podo_pkg::DW-1:0] DIST_MAX  = '1;
    localparam int                      PROD_BITS = podo_pkg::DW + 32;

    typedef struct packed {
        logic [podo_pkg::DW-1:0] total;
        logic [podo_pkg::DW-1:0] at_depth;
        logic [podo_pkg::DW-1:0] scaled;
        logic                    stale;
    } t_odo_result;

    // Results still owed by the block, oldest first.
    t_odo_result totals_due[$];

    // Shadow copy of the registers.
    logic signed [podo_pkg::CW-1:0]  depth_thr;
    logic [podo_pkg::TICK_W-1:0]     stale_limit;
    logic [podo_pkg::UNIT_SEL_W-1:0] unit_sel;

    // Shadow copy of the odometer state.
    logic                            have_fix;
    logic signed [podo_pkg::CW-1:0]  fix_x;
    logic signed [podo_pkg::CW-1:0]  fix_y;
    logic signed [podo_pkg::CW-1:0]  depth_now;
    logic [podo_pkg::DW-1:0]         dist_total;
    logic [podo_pkg::DW-1:0]         dist_deep;
    logic [podo_pkg::TICK_W-1:0]     quiet_ticks;

    int error_count = 0;

    // Floor of the square root, found one root bit at a time from the top.
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int b = podo_pkg::ROOT_W; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= v)
                root = cand;
        end
        return root;
    endfunction

    // Accumulator add that clamps at the largest distance.
    function automatic logic [podo_pkg::DW-1:0] sat_sum(input logic [podo_pkg::DW-1:0] a,
                                                        input logic [63:0] b);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        return (s > 65'(DIST_MAX)) ? DIST_MAX : s[podo_pkg::DW-1:0];
    endfunction

    // Unit factors in Q.24; codes without a unit count as metres.
    function automatic logic [31:0] unit_scale(input logic [podo_pkg::UNIT_SEL_W-1:0] sel);
        case (sel)
            podo_pkg::UNIT_FEET:  return 32'd55043361;
            podo_pkg::UNIT_YARDS: return 32'd18347731;
            podo_pkg::UNIT_KM:    return 32'd16777;
            podo_pkg::UNIT_MILES: return 32'd10425;
            default:              return 32'd16777216;
        endcase
    endfunction

    // Total converted to the selected unit, truncated and clamped.
    function automatic logic [podo_pkg::DW-1:0] in_units(
        input logic [podo_pkg::DW-1:0]         total,
        input logic [podo_pkg::UNIT_SEL_W-1:0] sel
    );
        logic [PROD_BITS-1:0] prod;
        prod = PROD_BITS'(total) * PROD_BITS'(unit_scale(sel));
        prod = prod >> podo_pkg::UNIT_FRAC;
        return (prod > PROD_BITS'(DIST_MAX)) ? DIST_MAX : prod[podo_pkg::DW-1:0];
    endfunction

    // Applies one input item to the shadow state and returns the result it causes.
    function automatic t_odo_result odometer_step(input logic [podo_pkg::CMD_W-1:0] cmd,
                                                  input logic [3*podo_pkg::CW-1:0] data);
        logic signed [podo_pkg::CW-1:0] nx;
        logic signed [podo_pkg::CW-1:0] ny;
        longint                         ddx;
        longint                         ddy;
        logic [63:0]                    sq;
        logic [63:0]                    step;
        t_odo_result                    res;
        nx = data[podo_pkg::CW-1:0];
        ny = data[2*podo_pkg::CW-1:podo_pkg::CW];
        case (cmd)
            podo_pkg::CMD_POS: begin
                // The first fix only sets the reference point.
                if (have_fix) begin
                    ddx = longint'(nx) - longint'(fix_x);
                    ddy = longint'(ny) - longint'(fix_y);
                    if (ddx < 0) ddx = -ddx;
                    if (ddy < 0) ddy = -ddy;
                    sq = ddx * ddx + ddy * ddy;
                    step = floor_root(sq);
                    dist_total = sat_sum(dist_total, step);
                    if (depth_now > depth_thr)
                        dist_deep = sat_sum(dist_deep, step);
                end
                have_fix = 1'b1;
                fix_x = nx;
                fix_y = ny;
                quiet_ticks = '0;
            end
            podo_pkg::CMD_DEPTH: begin
                depth_now = data[3*podo_pkg::CW-1:2*podo_pkg::CW];
                quiet_ticks = '0;
            end
            podo_pkg::CMD_TICK: begin
                if (quiet_ticks != '1)
                    quiet_ticks = quiet_ticks + 1'b1;
            end
            default: ;
        endcase
        res.total = dist_total;
        res.at_depth = dist_deep;
        res.scaled = in_units(dist_total, unit_sel);
        res.stale = quiet_ticks > stale_limit;
        return res;
    endfunction

    // Track register writes, compare finished results, then queue new predictions.
    always @(posedge i_clk) begin
        t_odo_result want;
        t_odo_result got;
        if (!i_rst_n) begin
            depth_thr = podo_pkg::DEPTH_THR_RESET;
            stale_limit = podo_pkg::STALE_TICKS_RESET;
            unit_sel = podo_pkg::UNIT_METRES;
            have_fix = 1'b0;
            fix_x = '0;
            fix_y = '0;
            depth_now = '0;
            dist_total = '0;
            dist_deep = '0;
            quiet_ticks = '0;
            totals_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    podo_pkg::REG_DEPTH_THR:
                        depth_thr = i_cfg_wdata[podo_pkg::CW-1:0];
                    podo_pkg::REG_STALE_TICKS:
                        stale_limit = i_cfg_wdata[podo_pkg::TICK_W-1:0];
                    podo_pkg::REG_UNIT_SEL:
                        unit_sel = i_cfg_wdata[podo_pkg::UNIT_SEL_W-1:0];
                    default: ;
                endcase
            end

            if (i_m_tvalid && i_m_tready) begin
                got.total = i_m_tdata[podo_pkg::DW-1:0];
                got.at_depth = i_m_tdata[2*podo_pkg::DW-1:podo_pkg::DW];
                got.scaled = i_m_tdata[3*podo_pkg::DW-1:2*podo_pkg::DW];
                got.stale = i_m_tuser[0];
                if (totals_due.size() == 0) begin
                    $error("result transfer with no item outstanding");
                    error_count++;
                end else begin
                    want = totals_due.pop_front();
                    if (got.total !== want.total) begin
                        $error("total_distance: expected %0d, actual %0d",
                               want.total, got.total);
                        error_count++;
                    end
                    if (got.at_depth !== want.at_depth) begin
                        $error("depth_distance: expected %0d, actual %0d",
                               want.at_depth, got.at_depth);
                        error_count++;
                    end
                    if (got.scaled !== want.scaled) begin
                        $error("scaled_distance: expected %0d, actual %0d",
                               want.scaled, got.scaled);
                        error_count++;
                    end
                    if (got.stale !== want.stale) begin
                        $error("stale: expected %0d, actual %0d", want.stale, got.stale);
                        error_count++;
                    end
                end
            end

            if (i_s_tvalid && i_s_tready)
                totals_due.push_back(odometer_step(i_s_tuser, i_s_tdata));
        end
        o_errors <= error_count;
        o_pending <= totals_due.size();
    end

endmodule

@@ verif/tb.sv @@
// Top of the planar odometry accumulator regression: clock, reset, stimulus and verdict.
// Instantiates planar_odometry_accumulator and podo_checker; uses podo_pkg.
`timescale 1ns / 1ps

module tb;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 48;
    localparam int PHASE_ITEMS   = 320;

    localparam logic [podo_pkg::CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [podo_pkg::CFG_IDX_W-1:0] REG_NONE   = 2'd3;

    localparam logic [podo_pkg::CW-1:0] COORD_MIN = {1'b1, {(podo_pkg::CW-1){1'b0}}};
    localparam logic [podo_pkg::CW-1:0] COORD_MAX = {1'b0, {(podo_pkg::CW-1){1'b1}}};

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [3*podo_pkg::CW-1:0]       s_tdata = '0;
    logic [podo_pkg::CMD_W-1:0]      s_tuser = podo_pkg::CMD_TICK;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [3*podo_pkg::DW-1:0]       m_tdata;
    logic [0:0]                      m_tuser;
    logic                            cfg_we = 1'b0;
    logic [podo_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [podo_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int errors;
    int pending;

    logic                    tx_gaps = 1'b1;
    logic                    rx_gaps = 1'b1;
    logic [podo_pkg::CW-1:0] cur_thr = podo_pkg::DEPTH_THR_RESET;
    logic [podo_pkg::CW-1:0] last_x = '0;
    logic [podo_pkg::CW-1:0] last_y = '0;
    int                      items_sent = 0;
    int                      fixes_sent = 0;
    int                      settings_used = 1;

    always #1 clk = ~clk;

    planar_odometry_accumulator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    podo_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // The receiver stalls at random unless stalls are switched off.
    always @(posedge clk)
        m_tready <= rx_gaps ? ($urandom_range(0, 99) >= 31) : 1'b1;

    // End the run if neither stream moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("planar_odometry_accumulator regression: fail");
        $finish;
    end

    // Offer one item and return at the edge where its transfer happens.
    task automatic send_item(input logic [podo_pkg::CMD_W-1:0] cmd,
                             input logic [podo_pkg::CW-1:0] x,
                             input logic [podo_pkg::CW-1:0] y,
                             input logic [podo_pkg::CW-1:0] d);
        while (tx_gaps && $urandom_range(0, 99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {d, y, x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        if (cmd == podo_pkg::CMD_POS)
            fixes_sent++;
    endtask

    // Stop sending and wait until every outstanding result has been taken.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [podo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [podo_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Program all three registers; bits above each register's width are noise.
    task automatic apply_setting(input logic [podo_pkg::CW-1:0] thr,
                                 input logic [podo_pkg::TICK_W-1:0] stale,
                                 input logic [podo_pkg::UNIT_SEL_W-1:0] unit);
        logic [podo_pkg::CFG_DATA_W-1:0] junk;
        junk = podo_pkg::CFG_DATA_W'($urandom);
        write_reg(podo_pkg::REG_DEPTH_THR, thr);
        write_reg(podo_pkg::REG_STALE_TICKS,
                  {junk[podo_pkg::CFG_DATA_W-1:podo_pkg::TICK_W], stale});
        junk = podo_pkg::CFG_DATA_W'($urandom);
        write_reg(podo_pkg::REG_UNIT_SEL,
                  {junk[podo_pkg::CFG_DATA_W-1:podo_pkg::UNIT_SEL_W], unit});
        cur_thr = thr;
        settings_used++;
    endtask

    function automatic logic [podo_pkg::CW-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return '1;
            4:       return podo_pkg::CW'(1);
            default: return podo_pkg::CW'($urandom);
        endcase
    endfunction

    // Mostly short hops between fixes, with depth changes near the threshold,
    // tick bursts that cross the stale limit, and some noise.
    task automatic random_items(input int n);
        int                      sent;
        int                      r;
        int                      burst;
        logic [podo_pkg::CW-1:0] x;
        logic [podo_pkg::CW-1:0] y;
        logic [podo_pkg::CW-1:0] d;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            x = podo_pkg::CW'($urandom);
            y = podo_pkg::CW'($urandom);
            d = podo_pkg::CW'($urandom);
            if (r < 45) begin
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    x = last_x + podo_pkg::CW'($urandom_range(0, 4095)) - podo_pkg::CW'(2048);
                    y = last_y + podo_pkg::CW'($urandom_range(0, 4095)) - podo_pkg::CW'(2048);
                end else if (r == 9) begin
                    x = pick_extreme();
                    y = pick_extreme();
                end
                last_x = x;
                last_y = y;
                send_item(podo_pkg::CMD_POS, x, y, d);
                sent++;
            end else if (r < 60) begin
                r = $urandom_range(0, 3);
                if (r < 2)
                    d = cur_thr + podo_pkg::CW'($urandom_range(0, 6)) - podo_pkg::CW'(3);
                else if (r == 2)
                    d = pick_extreme();
                send_item(podo_pkg::CMD_DEPTH, x, y, d);
                sent++;
            end else if (r < 92) begin
                burst = $urandom_range(1, 16);
                repeat (burst) begin
                    send_item(podo_pkg::CMD_TICK, podo_pkg::CW'($urandom),
                              podo_pkg::CW'($urandom), podo_pkg::CW'($urandom));
                    sent++;
                end
            end else begin
                send_item(CMD_UNUSED, x, y, d);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        // Reset once, then start from the register defaults.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first fix, largest steps, noise command, depth equal to threshold,
        // and the stale flag rising after the default limit.
        send_item(podo_pkg::CMD_TICK, '0, '0, '0);
        send_item(podo_pkg::CMD_POS, COORD_MIN, COORD_MIN, '0);
        send_item(podo_pkg::CMD_POS, COORD_MAX, COORD_MAX, '0);
        send_item(podo_pkg::CMD_POS, COORD_MIN, COORD_MAX, '0);
        send_item(CMD_UNUSED, podo_pkg::CW'($urandom), podo_pkg::CW'($urandom),
                  podo_pkg::CW'($urandom));
        send_item(podo_pkg::CMD_DEPTH, '0, '0, COORD_MAX);
        send_item(podo_pkg::CMD_POS, '0, '0, '0);
        repeat (11) send_item(podo_pkg::CMD_TICK, '0, '0, '0);
        settle();

        // Directed: zero stale limit, an unknown unit, depth above, at and below a zero
        // threshold.
        apply_setting('0, '0, 3'd5);
        send_item(podo_pkg::CMD_TICK, '0, '0, '0);
        send_item(podo_pkg::CMD_DEPTH, '0, '0, podo_pkg::CW'(1));
        send_item(podo_pkg::CMD_POS, podo_pkg::CW'(256), '0, '0);
        send_item(podo_pkg::CMD_DEPTH, '0, '0, '0);
        send_item(podo_pkg::CMD_POS, '0, '0, '0);
        send_item(podo_pkg::CMD_DEPTH, '0, '0, COORD_MIN);
        send_item(podo_pkg::CMD_POS, podo_pkg::CW'(1), podo_pkg::CW'(1), '0);
        send_item(CMD_UNUSED, '1, '1, '1);
        send_item(podo_pkg::CMD_POS, COORD_MAX, COORD_MIN, '0);
        send_item(podo_pkg::CMD_TICK, '0, '0, '0);
        settle();

        // Random phases over several register settings, with a drain halfway through
        // the first one.
        write_reg(REG_NONE, podo_pkg::CFG_DATA_W'($urandom));
        apply_setting('0, 16'd3, podo_pkg::UNIT_FEET);
        random_items(PHASE_ITEMS / 2);
        settle();
        random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
        settle();

        apply_setting(COORD_MIN, 16'd1, podo_pkg::UNIT_YARDS);
        random_items(PHASE_ITEMS);
        settle();

        // A long stretch with neither side idling.
        tx_gaps <= 1'b0;
        rx_gaps <= 1'b0;
        apply_setting(COORD_MAX, 16'hFFFF, podo_pkg::UNIT_KM);
        random_items(PHASE_ITEMS);
        settle();
        tx_gaps <= 1'b1;
        rx_gaps <= 1'b1;

        apply_setting(podo_pkg::CW'($urandom), podo_pkg::TICK_W'($urandom_range(2, 20)),
                      podo_pkg::UNIT_MILES);
        random_items(PHASE_ITEMS);
        settle();

        apply_setting(podo_pkg::CW'($urandom_range(0, 4095)) - podo_pkg::CW'(2048), '0,
                      podo_pkg::UNIT_SEL_W'($urandom_range(5, 7)));
        random_items(PHASE_ITEMS);
        settle();

        apply_setting(podo_pkg::CW'($urandom), 16'd10, podo_pkg::UNIT_METRES);
        random_items(PHASE_ITEMS);
        settle();

        $display("Covered %0d items (%0d position fixes) over %0d register settings,",
                 items_sent, fixes_sent, settings_used);
        $display("with first-fix, extreme-step, unknown-unit and stale-limit cases.");
        if (errors == 0 && pending == 0)
            $display("planar_odometry_accumulator regression: pass");
        else
            $display("planar_odometry_accumulator regression: fail");
        $finish;
    end

endmodule
